>>> hw/rtl/fft16_pkg.sv
`timescale 1ns / 1ps
package fft16_pkg;
  localparam int OUT_WIDTH = 21;
  localparam int TW_WIDTH  = 16;

  typedef enum logic [2:0] {
    ST_LOAD, ST_RD_B, ST_RD_A, ST_MUL, ST_WR_T, ST_WR_B, ST_OUT_RD, ST_OUT
  } state_t;

  // quarter-wave cosine in Q1.14, index 0..4 for angles 0..pi/2 in steps of 2pi/16
  function automatic logic signed [TW_WIDTH-1:0] quarter_cos(input logic [2:0] m);
    case (m)
      3'd0: quarter_cos = 16'sd16384;
      3'd1: quarter_cos = 16'sd15137;
      3'd2: quarter_cos = 16'sd11585;
      3'd3: quarter_cos = 16'sd6270;
      default: quarter_cos = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [TW_WIDTH-1:0] cos16(input logic [3:0] m);
    logic [3:0] t;
    if (m <= 4'd4) cos16 = quarter_cos(m[2:0]);
    else if (m <= 4'd8) begin
      t = 4'd8 - m;
      cos16 = -quarter_cos(t[2:0]);
    end else if (m <= 4'd12) begin
      t = m - 4'd8;
      cos16 = -quarter_cos(t[2:0]);
    end else begin
      t = 4'd0 - m;
      cos16 = quarter_cos(t[2:0]);
    end
  endfunction
endpackage

>>> hw/rtl/fft16_radix2_dit_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake            | payload
// in_       | in  | in_tvalid/in_tready  | in_tdata: sample_re[15:0], sample_im[31:16]
// out_      | out | out_tvalid/out_tready| out_tdata: bin_re[20:0], bin_im[41:21], bin_index[45:42]
//           |     |                      | out_tlast: last_bin
// a frame is loaded as 16 samples, then 32 butterflies run on one
// butterfly unit and one work memory (read b, read a, multiply, two writes),
// then 16 bins are emitted, each read from the memory and then presented
// rst_n is synchronous; it clears the control state, the memory is not cleared
// out_tready low holds the current bin; no input transfer while transforming
// or emitting
module fft16_radix2_dit_core #(
  parameter int POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // sample_re, sample_im
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // bin_re, bin_im, bin_index, zero fill
  output logic        out_tlast   // last_bin
);
  localparam int AW = $clog2(POINTS);
  localparam int SW = AW > 1 ? $clog2(AW) : 1;
  localparam int OW = fft16_pkg::OUT_WIDTH;
  localparam int PW = OW + fft16_pkg::TW_WIDTH;

  fft16_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;      // load / output / butterfly counter
  logic [SW-1:0] stage_r, stage_nxt;
  logic signed [OW-1:0] br_r, bi_r, tr_r, ti_r, ar_r, ai_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic mul_done_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [2*OW-1:0] wdata, rdata;
  logic [AW-1:0] rev, top, bot, half, tw_m;
  logic [3:0] m16;
  logic signed [fft16_pkg::TW_WIDTH-1:0] wr, wi;

  fft16_ram #(.WIDTH(2*OW), .DEPTH(POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt_r[AW-1-i];
  end

  // butterfly j of a stage: group = bits from the stage bit up, i = low bits
  always_comb begin
    logic [AW-1:0] lowmask;
    half = AW'(1) << stage_r;
    lowmask = half - AW'(1);
    top = ((cnt_r & ~lowmask) << 1) | (cnt_r & lowmask);
    bot = top | half;
    tw_m = (cnt_r & lowmask) << (AW - 1 - int'(stage_r));
    m16 = 4'((32'(tw_m) * 16) / POINTS);
    wr = fft16_pkg::cos16(m16);
    wi = -fft16_pkg::cos16(m16 + 4'd12);
  end

  function automatic logic signed [OW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + (PW'(1) <<< 13)) >>> 14;
    rnd = s[OW-1:0];
  endfunction

  logic signed [OW-1:0] t_re, t_im;
  assign t_re = rnd(p0_r) - rnd(p1_r);
  assign t_im = rnd(p2_r) + rnd(p3_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    stage_nxt = stage_r;
    we = 1'b0;
    waddr = bot;
    wdata = {ai_r - ti_r, ar_r - tr_r};
    raddr = bot;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      fft16_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        waddr = rev;
        wdata = {OW'($signed(in_tdata[31:16])), OW'($signed(in_tdata[15:0]))};
        if (in_tvalid) begin
          we = 1'b1;
          cnt_nxt = cnt_r + AW'(1);
          if (cnt_r == AW'(POINTS-1)) begin
            state_nxt = fft16_pkg::ST_RD_B;
            stage_nxt = '0;
          end
        end
      end
      fft16_pkg::ST_RD_B: state_nxt = fft16_pkg::ST_RD_A;
      fft16_pkg::ST_RD_A: begin
        raddr = top;
        state_nxt = fft16_pkg::ST_MUL;
      end
      fft16_pkg::ST_MUL: state_nxt = fft16_pkg::ST_WR_T;
      fft16_pkg::ST_WR_T: begin
        // products were registered in MUL; the twiddled b is formed on the fly
        we = 1'b1;
        waddr = top;
        wdata = {ai_r + t_im, ar_r + t_re};
        state_nxt = fft16_pkg::ST_WR_B;
      end
      fft16_pkg::ST_WR_B: begin
        we = 1'b1;
        state_nxt = fft16_pkg::ST_RD_B;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(POINTS/2-1)) begin
          cnt_nxt = '0;
          if (stage_r == SW'(AW-1)) state_nxt = fft16_pkg::ST_OUT_RD;
          else stage_nxt = stage_r + SW'(1);
        end
      end
      fft16_pkg::ST_OUT_RD: begin
        raddr = cnt_r;
        state_nxt = fft16_pkg::ST_OUT;
      end
      fft16_pkg::ST_OUT: begin
        raddr = cnt_r;
        out_tvalid = 1'b1;
        if (out_tready) begin
          cnt_nxt = cnt_r + AW'(1);
          state_nxt = (cnt_r == AW'(POINTS-1)) ? fft16_pkg::ST_LOAD : fft16_pkg::ST_OUT_RD;
        end
      end
      default: state_nxt = fft16_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fft16_pkg::ST_LOAD;
      cnt_r <= '0;
      stage_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      stage_r <= stage_nxt;
    end
  end

  // butterfly datapath: b arrives in RD_A, a in MUL, products ready for WR_T
  always_ff @(posedge clk) begin
    mul_done_r <= (state_r == fft16_pkg::ST_MUL);
    if (state_r == fft16_pkg::ST_RD_A) begin
      br_r <= rdata[OW-1:0];
      bi_r <= rdata[2*OW-1:OW];
    end
    if (state_r == fft16_pkg::ST_MUL) begin
      ar_r <= rdata[OW-1:0];
      ai_r <= rdata[2*OW-1:OW];
      p0_r <= PW'(br_r) * PW'(wr);
      p1_r <= PW'(bi_r) * PW'(wi);
      p2_r <= PW'(bi_r) * PW'(wr);
      p3_r <= PW'(br_r) * PW'(wi);
    end
    if (mul_done_r) begin
      tr_r <= t_re;
      ti_r <= t_im;
    end
  end

  assign out_tdata = {2'b00, 4'(cnt_r), rdata[2*OW-1:OW], rdata[OW-1:0]};
  assign out_tlast = (cnt_r == AW'(POINTS-1));
endmodule

>>> hw/rtl/fft16_ram.sv
`timescale 1ns / 1ps
module fft16_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> tb/tb_fft16_radix2_dit_core.sv
`timescale 1ns / 1ps
module tb_fft16_radix2_dit_core;

  typedef struct packed {
    logic signed [20:0] re;
    logic signed [20:0] im;
    logic [3:0]         idx;
    logic               last;
  } bin_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // sample_re, sample_im
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // bin_re, bin_im, bin_index, zero fill
  logic        out_tlast;  // last_bin

  fft16_radix2_dit_core dut (.*);

  // predictor state: frame buffer in bit-reversed order and load position
  longint frame_re[16];
  longint frame_im[16];
  int     load_pos;
  bin_t   bin_queue[$];
  int     mismatches;
  bit     draining;
  int     load_gaps;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint twiddle_cos(int m);
    longint qc[5];
    qc = '{16384, 15137, 11585, 6270, 0};
    m = m & 15;
    if (m <= 4) return qc[m];
    else if (m <= 8) return -qc[8 - m];
    else if (m <= 12) return -qc[m - 8];
    return qc[16 - m];
  endfunction

  // product rounded to nearest, half upward, back to q15
  function automatic longint round_mul(longint a, longint w);
    longint p;
    p = a * w + 64'sd8192;
    return p >>> 14;
  endfunction

  function automatic int bitrev4(int v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

  // runs the in-place butterflies and queues the 16 expected bins
  task automatic predict_spectrum();
    longint br, bi, ar, ai, tr, ti, wr, wi;
    int top, bot, m;
    bin_t b;
    for (int half = 1; half < 16; half <<= 1)
      for (int base = 0; base < 16; base += 2 * half)
        for (int i = 0; i < half; i++) begin
          m = (i * 16) / (2 * half);
          wr = twiddle_cos(m);
          wi = -twiddle_cos(m + 12);
          top = base + i;
          bot = top + half;
          br = frame_re[bot];
          bi = frame_im[bot];
          tr = round_mul(br, wr) - round_mul(bi, wi);
          ti = round_mul(bi, wr) + round_mul(br, wi);
          ar = frame_re[top];
          ai = frame_im[top];
          frame_re[top] = ar + tr;
          frame_im[top] = ai + ti;
          frame_re[bot] = ar - tr;
          frame_im[bot] = ai - ti;
        end
    for (int k = 0; k < 16; k++) begin
      b.re = frame_re[k][20:0];
      b.im = frame_im[k][20:0];
      b.idx = k[3:0];
      b.last = (k == 15);
      bin_queue.push_back(b);
    end
  endtask

  // one sample transfer, with a random gap first if load_gaps is set; tvalid stays up afterwards
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    int gap;
    gap = (load_gaps != 0) ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_re[bitrev4(load_pos)] = re;
    frame_im[bitrev4(load_pos)] = im;
    load_pos = (load_pos + 1) % 16;
    if (load_pos == 0) predict_spectrum();
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (bin_queue.size() != 0) @(posedge clk);
  endtask

  // result checker with random back-pressure
  initial begin
    bin_t got, want;
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (draining) stall = 0;
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got.re = out_tdata[20:0];
      got.im = out_tdata[41:21];
      got.idx = out_tdata[45:42];
      got.last = out_tlast;
      if (bin_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin transfer: re=%0d im=%0d idx=%0d last=%0b",
                   got.re, got.im, got.idx, got.last);
      end else begin
        want = bin_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"bin mismatch: exp re=%0d im=%0d idx=%0d last=%0b, ",
                      "got re=%0d im=%0d idx=%0d last=%0b"},
                     want.re, want.im, want.idx, want.last,
                     got.re, got.im, got.idx, got.last);
        end
      end
    end
  end

  // an impulse frame, then a frame of alternating extremes of both parts
  task automatic test_directed();
    send_sample(16'sd32767, 16'sd0);
    repeat (15) send_sample(16'sd0, 16'sd0);
    for (int i = 0; i < 16; i++)
      send_sample(i[0] ? -16'sd32768 : 16'sd32767, i[1] ? -16'sd32768 : 16'sd32767);
  endtask

  // full-scale constant frame drives the largest growth into bin zero
  task automatic test_full_scale();
    repeat (16) send_sample(-16'sd32768, -16'sd32768);
    // hold off until the whole spectrum is back
    wait_idle();
  endtask

  task automatic test_random_frames();
    for (int f = 0; f < 4; f++) begin
      load_gaps = (f != 2);
      for (int i = 0; i < 16; i++)
        send_sample(16'($urandom), 16'($urandom));
    end
    load_gaps = 1;
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    load_pos = 0;
    mismatches = 0;
    draining = 0;
    load_gaps = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_scale();
    test_random_frames();
    draining = 1;
    wait_idle();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && bin_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
